// ===== rtl/core/sss_pkg.sv =====
// Shared types and constants for the sample set statistics block.
// Used by the channel interfaces, the front, the job queue, the back and the top level.
package sss_pkg;

  // Sample store size and derived widths.
  localparam int MAX_SAMPLES = 1024;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int COUNT_W     = 11;
  localparam int SAMPLE_W    = 32;
  localparam int SUM_W       = 42;
  localparam int SQ_W        = 74;
  localparam int PROD_W      = 64;

  // Arithmetic unit widths in the back.
  localparam int ACC_W   = 86;
  localparam int MPL_W   = 42;
  localparam int DVD_W   = 98;
  localparam int DVS_W   = 21;
  localparam int RAD_W   = 80;
  localparam int ROOT_W  = 40;
  localparam int SREM_W  = 42;
  localparam int STEP_W  = 7;
  localparam int Q8_W    = 40;
  localparam int MED_W   = 33;

  localparam logic [STEP_W-1:0] MUL_LAST  = STEP_W'(MPL_W - 1);
  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(DVD_W - 1);
  localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(ROOT_W - 1);

  localparam logic [COUNT_W-1:0] STORE_FULL = COUNT_W'(MAX_SAMPLES);

  // One closed set handed from the front to the back.
  typedef struct packed {
    logic [COUNT_W-1:0]  n;
    logic [SUM_W-1:0]    sum;
    logic [SAMPLE_W-1:0] min_value;
    logic [SAMPLE_W-1:0] max_value;
    logic                overflow;
  } sss_job_t;

  // Queue push side.
  typedef struct packed {
    logic     valid;
    sss_job_t job;
  } sss_push_t;

  // Sample store write port.
  typedef struct packed {
    logic                we;
    logic [ADDR_W-1:0]   addr;
    logic [SAMPLE_W-1:0] data;
  } sss_wr_t;

  // Back sequencer states.
  typedef enum logic [3:0] {
    B_IDLE,
    B_SWEEP,
    B_SELSTEP,
    B_MUL1,
    B_MUL2,
    B_DIVV,
    B_DIVM,
    B_SQRT,
    B_DONE
  } sss_back_state_t;

endpackage

// ===== rtl/core/sss_channels.sv =====
// Valid/ready channel interfaces for samples in and statistics out.
// Depends on sss_pkg for field widths.
interface sss_sample_if;
  logic                          valid;
  logic                          ready;
  logic [sss_pkg::SAMPLE_W-1:0]  sample;
  logic                          last;
  modport source (output valid, sample, last, input ready);
  modport sink (input valid, sample, last, output ready);
endinterface

interface sss_stats_if;
  logic                          valid;
  logic                          ready;
  logic [sss_pkg::SAMPLE_W-1:0]  min_value;
  logic [sss_pkg::SAMPLE_W-1:0]  max_value;
  logic [sss_pkg::MED_W-1:0]     median_twice;
  logic [sss_pkg::Q8_W-1:0]      mean_q8;
  logic [sss_pkg::Q8_W-1:0]      stddev_q8;
  logic [sss_pkg::COUNT_W-1:0]   sample_count;
  logic                          overflow;
  modport source (output valid, min_value, max_value, median_twice, mean_q8, stddev_q8,
                  sample_count, overflow, input ready);
  modport sink (input valid, min_value, max_value, median_twice, mean_q8, stddev_q8,
                sample_count, overflow, output ready);
endinterface

// ===== rtl/core/sss_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module sss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/sss_front.sv =====
// Front: accepts samples, writes the store and keeps count, sum, min, max and drop flag.
// Depends on sss_pkg and sss_channels; hands closed sets to the job queue.
module sss_front (
  input  logic                   clk,
  input  logic                   rst,
  sss_sample_if.sink             samples,
  input  logic                   q_ready,
  input  logic                   release_store,
  output sss_pkg::sss_push_t     push,
  output sss_pkg::sss_wr_t       wr,
  output logic                   blocked
);

  logic [sss_pkg::COUNT_W-1:0]  kept;
  logic [sss_pkg::COUNT_W-1:0]  kept_next;
  logic [sss_pkg::SUM_W-1:0]    sum;
  logic [sss_pkg::SUM_W-1:0]    sum_next;
  logic [sss_pkg::SAMPLE_W-1:0] min_value;
  logic [sss_pkg::SAMPLE_W-1:0] min_next;
  logic [sss_pkg::SAMPLE_W-1:0] max_value;
  logic [sss_pkg::SAMPLE_W-1:0] max_next;
  logic                         dropped;
  logic                         dropped_next;
  logic                         take;
  logic                         has_room;

  assign samples.ready = !blocked && q_ready;
  assign take          = samples.valid && samples.ready;
  assign has_room      = kept < sss_pkg::STORE_FULL;

  // Classify the sample: kept and folded into the running values, or dropped.
  always_comb begin
    kept_next    = kept;
    sum_next     = sum;
    min_next     = min_value;
    max_next     = max_value;
    dropped_next = dropped;
    if (has_room) begin
      kept_next = kept + 1'b1;
      sum_next  = sum + sss_pkg::SUM_W'(samples.sample);
      if (kept == '0 || samples.sample < min_value) begin
        min_next = samples.sample;
      end
      if (kept == '0 || samples.sample > max_value) begin
        max_next = samples.sample;
      end
    end else begin
      dropped_next = 1'b1;
    end
  end

  // Store write port.
  always_comb begin
    wr.we   = take && has_room;
    wr.addr = kept[sss_pkg::ADDR_W-1:0];
    wr.data = samples.sample;
  end

  // A closed set goes to the queue on the transfer that carries last.
  always_comb begin
    push.valid         = take && samples.last;
    push.job.n         = kept_next;
    push.job.sum       = sum_next;
    push.job.min_value = min_next;
    push.job.max_value = max_next;
    push.job.overflow  = dropped_next;
  end

  // Running set state; the front blocks until the back has read out the store.
  always_ff @(posedge clk) begin
    if (rst) begin
      kept    <= '0;
      sum     <= '0;
      dropped <= 1'b0;
      blocked <= 1'b0;
    end else begin
      if (release_store) begin
        blocked <= 1'b0;
      end
      if (take) begin
        if (samples.last) begin
          kept    <= '0;
          sum     <= '0;
          dropped <= 1'b0;
          blocked <= 1'b1;
        end else begin
          kept    <= kept_next;
          sum     <= sum_next;
          dropped <= dropped_next;
        end
      end
    end
  end

  // Min and max carry no reset; the first kept sample loads them.
  always_ff @(posedge clk) begin
    if (take) begin
      min_value <= min_next;
      max_value <= max_next;
    end
  end

endmodule

// ===== rtl/core/sss_queue.sv =====
// Two-entry job queue between the front and the back.
// Depends on sss_pkg for the job type.
module sss_queue (
  input  logic               clk,
  input  logic               rst,
  input  sss_pkg::sss_push_t push,
  output logic               push_ready,
  output logic               pop_valid,
  output sss_pkg::sss_job_t  pop_job,
  input  logic               pop_ready
);

  sss_pkg::sss_job_t entries [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = count != 2'd2;
  assign pop_valid  = count != 2'd0;
  assign pop_job    = entries[rptr];
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= !wptr;
      end
      if (do_pop) begin
        rptr <= !rptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= push.job;
    end
  end

endmodule

// ===== rtl/core/sss_back.sv =====
// Back: radix selection of the two middle ranks over the store, sum of squares, then shift-add
// multiply, restoring divide and digit square root. Depends on sss_pkg and sss_channels.
module sss_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pop_valid,
  input  sss_pkg::sss_job_t             pop_job,
  output logic                          pop_ready,
  output logic [sss_pkg::ADDR_W-1:0]    raddr,
  input  logic [sss_pkg::SAMPLE_W-1:0]  rdata,
  output logic                          release_store,
  sss_stats_if.source                   stats
);

  sss_pkg::sss_back_state_t state;
  sss_pkg::sss_back_state_t state_next;

  // Set values.
  logic [sss_pkg::COUNT_W-1:0]  n;
  logic [sss_pkg::SUM_W-1:0]    sum;
  logic [sss_pkg::SAMPLE_W-1:0] mn;
  logic [sss_pkg::SAMPLE_W-1:0] mx;
  logic                         drop;
  logic [sss_pkg::DVS_W-1:0]    nsq;

  // Sweep and selection.
  logic [sss_pkg::COUNT_W-1:0]  addr;
  logic                         rv;
  logic                         pv;
  logic [sss_pkg::PROD_W-1:0]   prod;
  logic [sss_pkg::SQ_W-1:0]     sumsq;
  logic                         first;
  logic [sss_pkg::COUNT_W-1:0]  cnt;
  logic [sss_pkg::COUNT_W-1:0]  k;
  logic [sss_pkg::COUNT_W-1:0]  k2;
  logic [sss_pkg::SAMPLE_W-1:0] prefix;
  logic [sss_pkg::SAMPLE_W-1:0] prefix_next;
  logic [sss_pkg::SAMPLE_W-1:0] hmask;
  logic [sss_pkg::SAMPLE_W-1:0] bsel;
  logic                         which;
  logic [sss_pkg::SAMPLE_W-1:0] v1;
  logic                         below;
  logic                         match;
  logic                         issue;
  logic                         sweep_done;

  // Arithmetic unit.
  logic [sss_pkg::ACC_W-1:0]    acc;
  logic [sss_pkg::ACC_W-1:0]    acc_next;
  logic [sss_pkg::ACC_W-1:0]    mcand;
  logic [sss_pkg::MPL_W-1:0]    mplier;
  logic [sss_pkg::ACC_W-1:0]    p1;
  logic [sss_pkg::ACC_W-1:0]    dvar;
  logic [sss_pkg::STEP_W-1:0]   step;
  logic [sss_pkg::DVD_W-1:0]    dq;
  logic [sss_pkg::DVD_W-1:0]    dq_next;
  logic [sss_pkg::DVS_W-1:0]    rem;
  logic [sss_pkg::DVS_W-1:0]    rem_next;
  logic [sss_pkg::DVS_W:0]      div_t;
  logic                         div_ge;
  logic [sss_pkg::DVS_W-1:0]    divisor;
  logic [sss_pkg::RAD_W-1:0]    rq;
  logic [sss_pkg::ROOT_W-1:0]   root;
  logic [sss_pkg::ROOT_W-1:0]   root_next;
  logic [sss_pkg::SREM_W-1:0]   srem;
  logic [sss_pkg::SREM_W-1:0]   srem_next;
  logic [sss_pkg::SREM_W+1:0]   sq_t;
  logic [sss_pkg::SREM_W+1:0]   sq_trial;
  logic                         sq_ge;
  logic [sss_pkg::Q8_W-1:0]     mean;
  logic                         last_mul;
  logic                         last_div;
  logic                         last_sqrt;

  // Output register.
  logic                         ov;

  // Control outputs of the sequencer.
  always_comb begin
    pop_ready     = state == sss_pkg::B_IDLE;
    issue         = state == sss_pkg::B_SWEEP && addr < n;
    sweep_done    = state == sss_pkg::B_SWEEP && !issue && !rv && !pv;
    release_store = state == sss_pkg::B_SELSTEP && bsel[0] && which;
    last_mul      = step == sss_pkg::MUL_LAST;
    last_div      = step == sss_pkg::DIV_LAST;
    last_sqrt     = step == sss_pkg::SQRT_LAST;
    raddr         = addr[sss_pkg::ADDR_W-1:0];
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      sss_pkg::B_IDLE: begin
        if (pop_valid) begin
          state_next = sss_pkg::B_SWEEP;
        end
      end
      sss_pkg::B_SWEEP: begin
        if (sweep_done) begin
          state_next = sss_pkg::B_SELSTEP;
        end
      end
      sss_pkg::B_SELSTEP: begin
        state_next = (bsel[0] && which) ? sss_pkg::B_MUL1 : sss_pkg::B_SWEEP;
      end
      sss_pkg::B_MUL1: begin
        if (last_mul) begin
          state_next = sss_pkg::B_MUL2;
        end
      end
      sss_pkg::B_MUL2: begin
        if (last_mul) begin
          state_next = sss_pkg::B_DIVV;
        end
      end
      sss_pkg::B_DIVV: begin
        if (last_div) begin
          state_next = sss_pkg::B_DIVM;
        end
      end
      sss_pkg::B_DIVM: begin
        if (last_div) begin
          state_next = sss_pkg::B_SQRT;
        end
      end
      sss_pkg::B_SQRT: begin
        if (last_sqrt) begin
          state_next = sss_pkg::B_DONE;
        end
      end
      sss_pkg::B_DONE: begin
        if (!ov) begin
          state_next = sss_pkg::B_IDLE;
        end
      end
      default: state_next = sss_pkg::B_IDLE;
    endcase
  end

  // Selection compare and one step of each arithmetic unit.
  always_comb begin
    match       = ((rdata ^ prefix) & hmask) == '0 && (rdata & bsel) == '0;
    below       = k < cnt;
    prefix_next = below ? prefix : (prefix | bsel);
    acc_next    = mplier[0] ? acc + mcand : acc;
    dvar        = p1 - acc_next;
    div_t       = {rem, dq[sss_pkg::DVD_W-1]};
    div_ge      = div_t >= {1'b0, divisor};
    rem_next    = div_ge ? sss_pkg::DVS_W'(div_t - {1'b0, divisor})
                         : div_t[sss_pkg::DVS_W-1:0];
    dq_next     = {dq[sss_pkg::DVD_W-2:0], div_ge};
    sq_t        = {srem, rq[sss_pkg::RAD_W-1 -: 2]};
    sq_trial    = {2'b00, root, 2'b01};
    sq_ge       = sq_t >= sq_trial;
    srem_next   = sq_ge ? sss_pkg::SREM_W'(sq_t - sq_trial) : sq_t[sss_pkg::SREM_W-1:0];
    root_next   = {root[sss_pkg::ROOT_W-2:0], sq_ge};
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sss_pkg::B_IDLE;
      ov    <= 1'b0;
      rv    <= 1'b0;
      pv    <= 1'b0;
    end else begin
      state <= state_next;
      rv    <= issue;
      pv    <= rv && first;
      if (ov && stats.ready) begin
        ov <= 1'b0;
      end
      if (state == sss_pkg::B_DONE && !ov) begin
        ov <= 1'b1;
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    unique case (state)
      sss_pkg::B_IDLE: begin
        // Load a job and set up the first selection pass.
        if (pop_valid) begin
          n      <= pop_job.n;
          sum    <= pop_job.sum;
          mn     <= pop_job.min_value;
          mx     <= pop_job.max_value;
          drop   <= pop_job.overflow;
          nsq    <= sss_pkg::DVS_W'(pop_job.n * pop_job.n);
          k      <= (pop_job.n - 1'b1) >> 1;
          k2     <= pop_job.n >> 1;
          addr   <= '0;
          cnt    <= '0;
          prefix <= '0;
          hmask  <= '0;
          bsel   <= {1'b1, {(sss_pkg::SAMPLE_W-1){1'b0}}};
          which  <= 1'b0;
          first  <= 1'b1;
          sumsq  <= '0;
        end
      end
      sss_pkg::B_SWEEP: begin
        // Count entries that match the prefix and have a zero in the current bit; the first pass also squares.
        if (issue) begin
          addr <= addr + 1'b1;
        end
        if (rv) begin
          prod <= rdata * rdata;
          if (match) begin
            cnt <= cnt + 1'b1;
          end
        end
        if (pv) begin
          sumsq <= sumsq + sss_pkg::SQ_W'(prod);
        end
      end
      sss_pkg::B_SELSTEP: begin
        // Settle one bit of the selected value.
        cnt   <= '0;
        addr  <= '0;
        first <= 1'b0;
        if (bsel[0]) begin
          if (!which) begin
            v1     <= prefix_next;
            which  <= 1'b1;
            prefix <= '0;
            hmask  <= '0;
            bsel   <= {1'b1, {(sss_pkg::SAMPLE_W-1){1'b0}}};
            k      <= k2;
          end else begin
            prefix <= prefix_next;
            mcand  <= sss_pkg::ACC_W'(sumsq);
            mplier <= sss_pkg::MPL_W'(n);
            acc    <= '0;
            step   <= '0;
          end
        end else begin
          prefix <= prefix_next;
          hmask  <= hmask | bsel;
          bsel   <= bsel >> 1;
          if (!below) begin
            k <= k - cnt;
          end
        end
      end
      sss_pkg::B_MUL1: begin
        // n times the sum of squares.
        if (last_mul) begin
          p1     <= acc_next;
          acc    <= '0;
          mcand  <= sss_pkg::ACC_W'(sum);
          mplier <= sum;
          step   <= '0;
        end else begin
          acc    <= acc_next;
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          step   <= step + 1'b1;
        end
      end
      sss_pkg::B_MUL2: begin
        // Square of the sum, then the scaled spread goes to the divider.
        acc    <= acc_next;
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        step   <= last_mul ? '0 : step + 1'b1;
        if (last_mul) begin
          dq      <= {dvar[sss_pkg::DVD_W-17:0], 16'b0};
          divisor <= nsq;
          rem     <= '0;
        end
      end
      sss_pkg::B_DIVV: begin
        // Variance scaled by 65536, divided by n squared.
        if (last_div) begin
          rq      <= dq_next[sss_pkg::RAD_W-1:0];
          dq      <= {{(sss_pkg::DVD_W-sss_pkg::SUM_W-8){1'b0}}, sum, 8'b0};
          divisor <= sss_pkg::DVS_W'(n);
          rem     <= '0;
          step    <= '0;
        end else begin
          dq   <= dq_next;
          rem  <= rem_next;
          step <= step + 1'b1;
        end
      end
      sss_pkg::B_DIVM: begin
        // Mean with 8 fraction bits.
        dq   <= dq_next;
        rem  <= rem_next;
        step <= last_div ? '0 : step + 1'b1;
        if (last_div) begin
          mean <= dq_next[sss_pkg::Q8_W-1:0];
          srem <= '0;
          root <= '0;
        end
      end
      sss_pkg::B_SQRT: begin
        // Two radicand bits per step.
        srem <= srem_next;
        root <= root_next;
        rq   <= rq << 2;
        step <= last_sqrt ? '0 : step + 1'b1;
      end
      sss_pkg::B_DONE: begin
        // Load the result register once it is free.
        if (!ov) begin
          stats.min_value    <= mn;
          stats.max_value    <= mx;
          stats.median_twice <= sss_pkg::MED_W'(v1) + sss_pkg::MED_W'(prefix);
          stats.mean_q8      <= mean;
          stats.stddev_q8    <= root;
          stats.sample_count <= n;
          stats.overflow     <= drop;
        end
      end
      default: begin
      end
    endcase
  end

  assign stats.valid = ov;

endmodule

// ===== rtl/core/sample_set_statistics.sv =====
// Top level of the sample set statistics block.
// Depends on sss_pkg, sss_channels, sss_ram, sss_front, sss_queue and sss_back.
//
// Samples load at one per cycle into a 1024-entry store, while the front is not
// blocked and the queue has room, until a transfer marked last closes the set.
// Then the back reads the store with two radix selections of 32 passes each, one
// entry per cycle on the single read port, and the front takes no new sample
// until the back releases the store. After the release, the back goes on with
// multiply, divide and square root, which overlaps loading of the next set. A
// result waits in an output register until taken. Samples beyond 1024 are
// dropped and flagged in overflow.
module sample_set_statistics (
  input  logic        clk,
  input  logic        rst,
  sss_sample_if.sink  samples,
  sss_stats_if.source stats
);

  sss_pkg::sss_push_t           push;
  sss_pkg::sss_wr_t             wr;
  sss_pkg::sss_job_t            pop_job;
  logic                         q_ready;
  logic                         pop_valid;
  logic                         pop_ready;
  logic                         release_store;
  logic                         blocked;
  logic [sss_pkg::ADDR_W-1:0]   raddr;
  logic [sss_pkg::SAMPLE_W-1:0] rdata;

  sss_front u_front (
    .clk           (clk),
    .rst           (rst),
    .samples       (samples),
    .q_ready       (q_ready),
    .release_store (release_store),
    .push          (push),
    .wr            (wr),
    .blocked       (blocked)
  );

  sss_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (q_ready),
    .pop_valid  (pop_valid),
    .pop_job    (pop_job),
    .pop_ready  (pop_ready)
  );

  sss_ram #(
    .WIDTH (sss_pkg::SAMPLE_W),
    .DEPTH (sss_pkg::MAX_SAMPLES)
  ) u_store (
    .clk   (clk),
    .we    (wr.we),
    .waddr (wr.addr),
    .wdata (wr.data),
    .raddr (raddr),
    .rdata (rdata)
  );

  sss_back u_back (
    .clk           (clk),
    .rst           (rst),
    .pop_valid     (pop_valid),
    .pop_job       (pop_job),
    .pop_ready     (pop_ready),
    .raddr         (raddr),
    .rdata         (rdata),
    .release_store (release_store),
    .stats         (stats)
  );

  // The store is only released to a front that is waiting on it.
  a_release_blocked: assert property (@(posedge clk) disable iff (rst)
    release_store |-> blocked)
    else $error("store released while the front was not waiting");

  // The front never writes the store while it is blocked.
  a_no_write_blocked: assert property (@(posedge clk) disable iff (rst)
    blocked |-> !wr.we)
    else $error("store written while a set is being read");

  // A result always covers at least one sample.
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    stats.valid |-> stats.sample_count != '0)
    else $error("result with an empty set");

  // Minimum never exceeds maximum.
  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    stats.valid |-> stats.min_value <= stats.max_value)
    else $error("minimum above maximum");

endmodule
